FILE: hdl/pmx_pkg.sv
package pmx_pkg;

	localparam int GENE_COUNT_DEF = 512;
	localparam int GENE_W         = 9;
	localparam int LEN_W          = 10;

	// transaction opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	// registered read data of the four gene/position stores
	typedef struct packed {
		logic [GENE_W-1:0] first_gene;
		logic [GENE_W-1:0] second_gene;
		logic [GENE_W-1:0] where_first;
		logic [GENE_W-1:0] where_second;
	} pmx_rd_t;

	// one finished read transaction
	typedef struct packed {
		logic [GENE_W-1:0] child_first;
		logic [GENE_W-1:0] child_second;
		logic [GENE_W-1:0] read_position;
		logic              map_error;
	} pmx_result_t;

endpackage

FILE: hdl/partially_mapped_crossover.sv
// Partially mapped crossover engine. Load transactions (op 0) write both
// parents' genes at a position and record where each gene value sits; they
// return nothing and do not hold off the item channel. Read transactions
// (op 1) return both children's genes at a position for the window
// [cut_start, cut_start + cut_length). A read inside the window needs no
// mapping; outside it, each child's gene is mapped through the window by
// one shared walker, each mapping step being one position-table read and
// then one gene-table read, both from registered RAM ports. The block takes
// one transaction at a time: item_stall stays high from acceptance of a
// read until its result moves into the output register. A result in the
// output register does not block the next item. Reading a position that
// was never loaded gives undefined genes.
module partially_mapped_crossover import pmx_pkg::*; #(
	parameter int GENE_COUNT = GENE_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// item channel
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              op,
	input  logic [GENE_W-1:0] position,
	input  logic [GENE_W-1:0] gene_first,
	input  logic [GENE_W-1:0] gene_second,
	input  logic [GENE_W-1:0] cut_start,
	input  logic [LEN_W-1:0]  cut_length,
	// result channel
	output logic              result_valid,
	input  logic              result_stall,
	output logic [GENE_W-1:0] child_first,
	output logic [GENE_W-1:0] child_second,
	output logic [GENE_W-1:0] read_position,
	output logic              map_error
);

	localparam int AW = (GENE_COUNT > 1) ? $clog2(GENE_COUNT) : 1;
	localparam int CW = (GENE_W + 2 > $clog2(GENE_COUNT + 1)) ? GENE_W + 2
		: $clog2(GENE_COUNT + 1);
	localparam logic [CW-1:0] GC_C = CW'(GENE_COUNT);

	logic        accept, load_en, read_start, busy;
	logic        res_valid, res_take;
	logic [AW-1:0] gene_addr, where_addr;
	pmx_rd_t     rd;
	pmx_result_t res;

	logic        out_valid_q;
	pmx_result_t out_q;

	assign item_stall = busy;
	assign accept     = item_valid && !item_stall;
	// drop loads aimed past the end of the chromosome
	assign load_en    = accept && (op == OP_LOAD) && (CW'(position) < GC_C);
	assign read_start = accept && (op == OP_READ);

	pmx_store #(
		.GENE_COUNT (GENE_COUNT),
		.AW         (AW)
	) u_store (
		.clk            (clk),
		.wr_en          (load_en),
		.wr_position    (position),
		.wr_gene_first  (gene_first),
		.wr_gene_second (gene_second),
		.gene_addr      (gene_addr),
		.where_addr     (where_addr),
		.rd             (rd)
	);

	pmx_walker #(
		.GENE_COUNT (GENE_COUNT),
		.AW         (AW)
	) u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (read_start),
		.position   (position),
		.cut_start  (cut_start),
		.cut_length (cut_length),
		.rd         (rd),
		.gene_addr  (gene_addr),
		.where_addr (where_addr),
		.busy       (busy),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.result     (res)
	);

	// advance a finished read into the output register when it is empty or draining
	assign res_take = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_take) begin
				out_valid_q <= res_valid;
				if (res_valid) begin
					out_q <= res;
				end
			end
		end
	end

	assign result_valid  = out_valid_q;
	assign child_first   = out_q.child_first;
	assign child_second  = out_q.child_second;
	assign read_position = out_q.read_position;
	assign map_error     = out_q.map_error;

	a_load_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_LOAD) |=> !item_stall)
		else $error("load transaction left block busy");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		read_start |=> item_stall)
		else $error("read transaction did not hold off the item channel");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid && $stable(out_q))
		else $error("stalled result changed");

endmodule

FILE: hdl/pmx_store.sv
module pmx_store import pmx_pkg::*; #(
	parameter int GENE_COUNT = GENE_COUNT_DEF,
	parameter int AW         = $clog2(GENE_COUNT)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [GENE_W-1:0] wr_position,
	input  logic [GENE_W-1:0] wr_gene_first,
	input  logic [GENE_W-1:0] wr_gene_second,
	input  logic [AW-1:0]     gene_addr,
	input  logic [AW-1:0]     where_addr,
	output pmx_rd_t           rd
);

	localparam int CW = (GENE_W + 2 > $clog2(GENE_COUNT + 1)) ? GENE_W + 2
		: $clog2(GENE_COUNT + 1);
	localparam logic [CW-1:0] GC_C = CW'(GENE_COUNT);

	logic [GENE_W-1:0] first_genes_q  [GENE_COUNT];
	logic [GENE_W-1:0] second_genes_q [GENE_COUNT];
	logic [GENE_W-1:0] where_first_q  [GENE_COUNT];
	logic [GENE_W-1:0] where_second_q [GENE_COUNT];

	logic first_ok, second_ok;

	// gene values beyond the chromosome are stored but get no position entry
	assign first_ok  = CW'(wr_gene_first) < GC_C;
	assign second_ok = CW'(wr_gene_second) < GC_C;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			first_genes_q[AW'(wr_position)]  <= wr_gene_first;
			second_genes_q[AW'(wr_position)] <= wr_gene_second;
		end
		if (wr_en && first_ok) begin
			where_first_q[AW'(wr_gene_first)] <= wr_position;
		end
		if (wr_en && second_ok) begin
			where_second_q[AW'(wr_gene_second)] <= wr_position;
		end
	end

	always_ff @(posedge clk) begin
		rd.first_gene   <= first_genes_q[gene_addr];
		rd.second_gene  <= second_genes_q[gene_addr];
		rd.where_first  <= where_first_q[where_addr];
		rd.where_second <= where_second_q[where_addr];
	end

endmodule

FILE: hdl/pmx_walker.sv
module pmx_walker import pmx_pkg::*; #(
	parameter int GENE_COUNT = GENE_COUNT_DEF,
	parameter int AW         = $clog2(GENE_COUNT)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [GENE_W-1:0] position,
	input  logic [GENE_W-1:0] cut_start,
	input  logic [LEN_W-1:0]  cut_length,
	input  pmx_rd_t           rd,
	output logic [AW-1:0]     gene_addr,
	output logic [AW-1:0]     where_addr,
	output logic              busy,
	output logic              res_valid,
	input  logic              res_take,
	output pmx_result_t       result
);

	localparam int CW = (GENE_W + 2 > $clog2(GENE_COUNT + 1)) ? GENE_W + 2
		: $clog2(GENE_COUNT + 1);
	localparam logic [CW-1:0] GC_C = CW'(GENE_COUNT);

	typedef enum logic [2:0] {
		S_IDLE,
		S_GENES,
		S_WHERE,
		S_GENE,
		S_SWITCH,
		S_END,
		S_DONE
	} state_t;

	state_t            state_q;
	logic              chain_q;
	logic [GENE_W-1:0] pos_q, val_q, c1_q, c2_q;
	logic              err_q;
	logic [CW-1:0]     lo_q, hi_q, limit_q, steps_q;

	logic [CW-1:0]     sum, hi_n, lo_n, start_ext, pos_ext, d_ext;
	logic              sum_over, pos_bad, in_window;
	logic [GENE_W-1:0] own_gene, other_where, launch_val;
	logic              launch_out, d_out, lim_hit;

	assign start_ext = CW'(cut_start);
	assign sum       = start_ext + CW'(cut_length);
	assign sum_over  = sum > GC_C;
	assign hi_n      = sum_over ? GC_C : sum;
	assign lo_n      = (start_ext > hi_n) ? hi_n : start_ext;
	assign pos_bad   = CW'(position) >= GC_C;

	assign pos_ext   = CW'(pos_q);
	assign in_window = (pos_ext >= lo_q) && (pos_ext < hi_q);

	// chain 0 maps the first parent through the second's positions, chain 1 the reverse
	assign own_gene    = chain_q ? rd.second_gene : rd.first_gene;
	assign other_where = chain_q ? rd.where_first : rd.where_second;

	always_comb begin
		case (state_q)
			S_GENES: launch_val = rd.first_gene;
			S_GENE:  launch_val = own_gene;
			default: launch_val = val_q;
		endcase
	end

	assign launch_out = CW'(launch_val) >= GC_C;
	assign d_ext      = CW'(other_where);
	assign d_out      = (d_ext < lo_q) || (d_ext >= hi_q) || (d_ext >= GC_C);
	assign lim_hit    = steps_q >= limit_q;

	assign where_addr = AW'(launch_val);
	assign gene_addr  = (state_q == S_WHERE) ? AW'(other_where) : AW'(position);

	assign busy      = state_q != S_IDLE;
	assign res_valid = state_q == S_DONE;

	assign result.child_first   = c1_q;
	assign result.child_second  = c2_q;
	assign result.read_position = pos_q;
	assign result.map_error     = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chain_q <= 1'b0;
			pos_q   <= '0;
			val_q   <= '0;
			c1_q    <= '0;
			c2_q    <= '0;
			err_q   <= 1'b0;
			lo_q    <= '0;
			hi_q    <= '0;
			limit_q <= '0;
			steps_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						pos_q   <= position;
						lo_q    <= lo_n;
						hi_q    <= hi_n;
						err_q   <= sum_over || pos_bad;
						chain_q <= 1'b0;
						steps_q <= '0;
						c1_q    <= '0;
						c2_q    <= '0;
						state_q <= pos_bad ? S_DONE : S_GENES;
					end
				end
				S_GENES: begin
					limit_q <= hi_q - lo_q;
					if (in_window) begin
						c1_q    <= rd.second_gene;
						c2_q    <= rd.first_gene;
						state_q <= S_DONE;
					end else begin
						// park the second parent's gene until chain 1 starts
						c2_q    <= rd.second_gene;
						val_q   <= launch_val;
						state_q <= launch_out ? S_END : S_WHERE;
					end
				end
				S_GENE, S_SWITCH: begin
					val_q   <= launch_val;
					state_q <= launch_out ? S_END : S_WHERE;
				end
				S_WHERE: begin
					if (d_out) begin
						state_q <= S_END;
					end else if (lim_hit) begin
						err_q   <= 1'b1;
						state_q <= S_END;
					end else begin
						steps_q <= steps_q + 1'b1;
						state_q <= S_GENE;
					end
				end
				S_END: begin
					if (!chain_q) begin
						c1_q    <= val_q;
						val_q   <= c2_q;
						chain_q <= 1'b1;
						steps_q <= '0;
						state_q <= S_SWITCH;
					end else begin
						c2_q    <= val_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == S_IDLE)
		else $error("read started while walker busy");

	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (lo_q <= hi_q) && (hi_q <= GC_C))
		else $error("cut window out of order or past end");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GENE) |-> (steps_q <= limit_q) && (steps_q != '0))
		else $error("chain step count beyond window length");

	a_err_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(start && pos_bad) |=> (state_q == S_DONE) && err_q)
		else $error("out-of-range read did not flag error");

endmodule
